[rtl/core/eia_pkg.sv]
// ----------------------------------------------------------------------------
// Extended integer arithmetic package
// Operation codes, write masks and the payload types of the arithmetic unit.
// ----------------------------------------------------------------------------
package eia_pkg;

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_DIV  = 2'd1,
    CMD_ASH  = 2'd2,
    CMD_ASHC = 2'd3
  } cmd_t;

  localparam logic [1:0] WM_NONE = 2'd0;
  localparam logic [1:0] WM_HIGH = 2'd1;
  localparam logic [1:0] WM_BOTH = 2'd2;

  localparam int DivStages = 8;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] reg_high;
    logic [15:0] reg_low;
    logic [15:0] source;
  } operands_t;

  typedef struct packed {
    logic [15:0] result_high;
    logic [15:0] result_low;
    logic [1:0]  write_mask;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
  } result_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] acc;
    logic [1:0]  wm;
    logic        n;
    logic        z;
    logic        v;
    logic        c;
    logic [15:0] dmag;
    logic        qneg;
    logic        rneg;
    logic        dzero;
    logic        dovf;
  } stage_t;

endpackage

[rtl/core/extended_integer_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// Extended integer arithmetic unit
// An operation passes stage registers 0 to 8; done is registered from stage 8.
// Throughput: one operation per cycle; busy stays low, the pipeline never stalls.
// Stage depth is set by the divider: two quotient bits per stage over 8 stages.
// Reset clears the stage valid bits and the done strobe; payload is not reset.
// MUL, DIV, ASH and ASHC on a register pair and a 16-bit source operand.
// ----------------------------------------------------------------------------
module extended_integer_arith_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  eia_pkg::operands_t operands,
  output logic               done,
  output eia_pkg::result_t   result
);

  function automatic logic [33:0] shift_f(input logic wide, input logic [31:0] val,
                                          input logic [5:0] cnt);
    logic [63:0] u;
    logic [63:0] sh;
    logic [63:0] ones;
    logic [63:0] span;
    logic [31:0] res;
    logic [6:0]  amt;
    logic        c;
    logic        v;
    u    = wide ? {{32{val[31]}}, val} : {{48{val[15]}}, val[15:0]};
    res  = val;
    c    = 1'b0;
    v    = 1'b0;
    sh   = '0;
    ones = '0;
    span = '0;
    amt  = '0;
    if (cnt[5]) begin
      amt = 7'd64 - {1'b0, cnt};
      sh  = $signed(u) >>> (amt - 7'd1);
      c   = sh[0];
      sh  = $signed(sh) >>> 1;
      res = sh[31:0];
    end else if (cnt != 6'd0) begin
      sh   = u << cnt;
      ones = (64'd1 << ({1'b0, cnt} + 7'd1)) - 64'd1;
      span = (wide ? (sh >> 31) : (sh >> 15)) & ones;
      c    = wide ? sh[32] : sh[16];
      v    = (span != 64'd0) && (span != ones);
      res  = sh[31:0];
    end
    if (!wide) begin
      res = {16'd0, res[15:0]};
    end
    return {v, c, res};
  endfunction

  eia_pkg::stage_t pipe [eia_pkg::DivStages+1];
  logic            valid [eia_pkg::DivStages+1];
  eia_pkg::stage_t pipe_next [eia_pkg::DivStages+1];

  eia_pkg::stage_t entry;
  logic [31:0]     prod;
  logic [31:0]     dvd;
  logic [31:0]     dmag32;
  logic [15:0]     smag;
  logic [33:0]     sh_res;
  logic            wide;

  eia_pkg::result_t result_next;
  logic [15:0]      q;
  logic [15:0]      r;
  logic             qovf;

  assign busy = 1'b0;

  always_comb begin
    entry        = '0;
    entry.cmd    = operands.cmd;
    prod         = 32'($signed(operands.reg_high) * $signed(operands.source));
    dvd          = {operands.reg_high, operands.reg_low};
    dmag32       = dvd[31] ? (32'd0 - dvd) : dvd;
    smag         = operands.source[15] ? (16'd0 - operands.source) : operands.source;
    wide         = (operands.cmd == eia_pkg::CMD_ASHC);
    sh_res       = shift_f(wide, wide ? dvd : {16'd0, operands.reg_high},
                           operands.source[5:0]);
    case (operands.cmd)
      eia_pkg::CMD_MUL: begin
        entry.acc = prod;
        entry.wm  = eia_pkg::WM_BOTH;
        entry.n   = prod[31];
        entry.z   = (prod == 32'd0);
        entry.c   = (prod[31:15] != 17'd0) && (prod[31:15] != 17'h1FFFF);
      end
      eia_pkg::CMD_DIV: begin
        entry.acc   = dmag32;
        entry.dmag  = smag;
        entry.qneg  = dvd[31] ^ operands.source[15];
        entry.rneg  = dvd[31];
        entry.dzero = (operands.source == 16'd0);
        entry.dovf  = (dmag32[31:16] >= smag);
      end
      eia_pkg::CMD_ASH: begin
        entry.acc = {sh_res[15:0], 16'd0};
        entry.wm  = eia_pkg::WM_HIGH;
        entry.n   = sh_res[15];
        entry.z   = (sh_res[15:0] == 16'd0);
        entry.v   = sh_res[33];
        entry.c   = sh_res[32];
      end
      default: begin
        entry.acc = sh_res[31:0];
        entry.wm  = eia_pkg::WM_BOTH;
        entry.n   = sh_res[31];
        entry.z   = (sh_res[31:0] == 32'd0);
        entry.v   = sh_res[33];
        entry.c   = sh_res[32];
      end
    endcase
  end

  always_comb begin
    logic [16:0] t;
    t = '0;
    pipe_next[0] = entry;
    for (int k = 0; k < eia_pkg::DivStages; k++) begin
      pipe_next[k+1] = pipe[k];
      if (pipe[k].cmd == eia_pkg::CMD_DIV && !pipe[k].dzero && !pipe[k].dovf) begin
        for (int s = 0; s < 2; s++) begin
          t = pipe_next[k+1].acc[31:15];
          if (t >= {1'b0, pipe[k].dmag}) begin
            t = t - {1'b0, pipe[k].dmag};
            pipe_next[k+1].acc = {t[15:0], pipe_next[k+1].acc[14:0], 1'b1};
          end else begin
            pipe_next[k+1].acc = {t[15:0], pipe_next[k+1].acc[14:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    eia_pkg::stage_t last;
    last = pipe[eia_pkg::DivStages];
    q    = last.acc[15:0];
    r    = last.acc[31:16];
    qovf = last.dovf || (last.qneg ? (q > 16'h8000) : q[15]);
    result_next.result_high = last.acc[31:16];
    result_next.result_low  = last.acc[15:0];
    result_next.write_mask  = last.wm;
    result_next.flag_n      = last.n;
    result_next.flag_z      = last.z;
    result_next.flag_v      = last.v;
    result_next.flag_c      = last.c;
    if (last.cmd == eia_pkg::CMD_DIV) begin
      if (last.dzero || qovf) begin
        result_next.result_high = '0;
        result_next.result_low  = '0;
        result_next.write_mask  = eia_pkg::WM_NONE;
        result_next.flag_n      = 1'b0;
        result_next.flag_z      = 1'b0;
        result_next.flag_v      = 1'b1;
        result_next.flag_c      = last.dzero;
      end else begin
        result_next.result_high = last.qneg ? (16'd0 - q) : q;
        result_next.result_low  = last.rneg ? (16'd0 - r) : r;
        result_next.write_mask  = eia_pkg::WM_BOTH;
        result_next.flag_n      = last.qneg && (q != 16'd0);
        result_next.flag_z      = (q == 16'd0);
        result_next.flag_v      = 1'b0;
        result_next.flag_c      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= eia_pkg::DivStages; k++) begin
        valid[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      valid[0] <= start;
      for (int k = 0; k < eia_pkg::DivStages; k++) begin
        valid[k+1] <= valid[k];
      end
      done <= valid[eia_pkg::DivStages];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= eia_pkg::DivStages; k++) begin
      pipe[k] <= pipe_next[k];
    end
    result <= result_next;
  end

endmodule
